/* hw/rtl/icv_pkg.sv */
package icv_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_HEIGHT   = 4096;
  localparam int LB_AW        = $clog2(MAX_WIDTH);
  localparam int QDEPTH       = 4;
  localparam int QAW          = $clog2(QDEPTH);
  localparam int QCW          = $clog2(QDEPTH + 2);
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  typedef enum logic [2:0] {
    K_EDGE    = 3'd0,
    K_SHARPEN = 3'd1,
    K_BOX     = 3'd2,
    K_GAUSS   = 3'd3,
    K_EMBOSS  = 3'd4,
    K_IDENT   = 3'd5
  } kern_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL   = 8'd0,
    REG_WIDTH    = 8'd1,
    REG_HEIGHT   = 8'd2,
    REG_CHANNELS = 8'd3
  } reg_e;

  typedef logic [8:0][31:0] win_t;

  typedef struct packed {
    logic [2:0]  kernel;
    logic [11:0] width;
    logic [12:0] height;
    logic [2:0]  chans;
  } cfg_t;

  typedef struct packed {
    win_t        win;
    logic [10:0] col;
    logic [11:0] row;
    logic [3:0]  mask;
    logic        col_one;
    logic        col_zero;
  } entry_t;

endpackage

/* hw/rtl/icv_if.sv */
interface pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [7:0] chan_c;
  logic [7:0] chan_d;
  modport source (output valid, chan_a, chan_b, chan_c, chan_d, input ready);
  modport sink (input valid, chan_a, chan_b, chan_c, chan_d, output ready);
endinterface

interface res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  res_a;
  logic [7:0]  res_b;
  logic [7:0]  res_c;
  logic [7:0]  res_d;
  logic [10:0] out_col;
  logic [11:0] out_row;
  logic        run_last;
  modport source (output valid, res_a, res_b, res_c, res_d, out_col, out_row, run_last,
                  input ready);
  modport sink (input valid, res_a, res_b, res_c, res_d, out_col, out_row, run_last,
                output ready);
endinterface

interface cfg_if;
  logic                            valid;
  logic                            ready;
  logic [icv_pkg::CFG_IDX_W-1:0]   index;
  logic [icv_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/icv_front.sv */
module icv_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pix_if.sink                         in_if,
  input  icv_pkg::cfg_t               cfg_i,
  input  logic [icv_pkg::QCW-1:0]     fifo_count_i,
  output logic                        push_o,
  output icv_pkg::entry_t             entry_o
);
  import icv_pkg::*;

  logic [63:0]      lb_mem [MAX_WIDTH];
  logic [63:0]      rd_q;
  logic [10:0]      col_q, col_d;
  logic [11:0]      row_q, row_d;
  logic [11:0]      w_eff;
  logic [12:0]      h_eff;
  logic             last_col, last_row, accept;
  logic             s1_valid_q;
  logic [31:0]      s1_cur_q;
  logic [10:0]      s1_col_q;
  logic [11:0]      s1_row_q;
  logic [3:0]       s1_mask_q, mask_d;
  logic             byp_q, byp_d;
  logic [31:0]      byp_prev_q, byp_older_q;
  logic [31:0]      cur, p_raw, o_raw, p_val, o_val;
  win_t             win_q, win_d;

  always_comb begin
    if (cfg_i.width == 12'd0) w_eff = 12'd1;
    else if (cfg_i.width > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
    else w_eff = cfg_i.width;
    if (cfg_i.height == 13'd0) h_eff = 13'd1;
    else if (cfg_i.height > 13'(MAX_HEIGHT)) h_eff = 13'(MAX_HEIGHT);
    else h_eff = cfg_i.height;
  end

  assign last_col = {1'b0, col_q} >= (w_eff - 12'd1);
  assign last_row = {1'b0, row_q} >= (h_eff - 13'd1);
  // reserve queue room for the word still in the read stage
  assign in_if.ready = (fifo_count_i + QCW'(s1_valid_q)) < QCW'(QDEPTH);
  assign accept = in_if.valid && in_if.ready;
  assign cur = {in_if.chan_d, in_if.chan_c, in_if.chan_b, in_if.chan_a};

  always_comb begin
    mask_d[0] = (row_q != 12'd0) && (col_q != 11'd0);
    mask_d[1] = (row_q != 12'd0) && last_col;
    mask_d[2] = last_row && (col_q != 11'd0);
    mask_d[3] = last_row && last_col;
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = 11'd0;
      row_d = last_row ? 12'd0 : row_q + 12'd1;
    end else begin
      col_d = col_q + 11'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
      win_q      <= '0;
    end else begin
      s1_valid_q <= accept;
      byp_q      <= byp_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (s1_valid_q) win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q      <= lb_mem[col_q[LB_AW-1:0]];
      s1_cur_q  <= cur;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_mask_q <= mask_d;
    end
    if (s1_valid_q) lb_mem[s1_col_q[LB_AW-1:0]] <= {s1_cur_q, p_raw};
    byp_prev_q  <= s1_cur_q;
    byp_older_q <= p_raw;
  end

  // same-address read and write in one cycle: forward the write
  assign byp_d = s1_valid_q && accept && (col_q == s1_col_q);
  assign p_raw = byp_q ? byp_prev_q  : rd_q[63:32];
  assign o_raw = byp_q ? byp_older_q : rd_q[31:0];

  always_comb begin
    p_val = p_raw;
    o_val = o_raw;
    if (s1_row_q == 12'd0) begin
      p_val = s1_cur_q;
      o_val = s1_cur_q;
    end else if (s1_row_q == 12'd1) begin
      o_val = p_raw;
    end
    win_d = win_q;
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = o_val;
    win_d[5] = p_val;
    win_d[8] = s1_cur_q;
  end

  assign push_o           = s1_valid_q && (s1_mask_q != 4'd0);
  assign entry_o.win      = win_d;
  assign entry_o.col      = s1_col_q;
  assign entry_o.row      = s1_row_q;
  assign entry_o.mask     = s1_mask_q;
  assign entry_o.col_one  = (s1_col_q == 11'd1);
  assign entry_o.col_zero = (s1_col_q == 11'd0);

endmodule

/* hw/rtl/icv_fifo.sv */
module icv_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  icv_pkg::entry_t         entry_i,
  input  logic                    pop_i,
  output icv_pkg::entry_t         head_o,
  output logic                    empty_o,
  output logic [icv_pkg::QCW-1:0] count_o
);
  import icv_pkg::*;

  entry_t           mem_q [QDEPTH];
  logic [QAW-1:0]   wr_q, rd_q;
  logic [QCW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QAW'(1);
      if (pop_i) rd_q <= rd_q + QAW'(1);
      cnt_q <= cnt_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  assign head_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

/* hw/rtl/icv_back.sv */
module icv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  icv_pkg::cfg_t   cfg_i,
  input  icv_pkg::entry_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  res_if.source           out_if
);
  import icv_pkg::*;

  function automatic logic [7:0] filt(input logic [8:0][7:0] v, input logic [2:0] ksel);
    logic signed [13:0] e [9];
    logic signed [13:0] s;
    logic [11:0]        bsum;
    logic [11:0]        gsum;
    logic [24:0]        prod;
    for (int i = 0; i < 9; i++) e[i] = $signed({6'd0, v[i]});
    bsum = '0;
    for (int i = 0; i < 9; i++) bsum = bsum + 12'(v[i]);
    gsum = 12'(v[0]) + 12'(v[2]) + 12'(v[6]) + 12'(v[8])
         + {1'b0, 10'(v[1]) + 10'(v[3]) + 10'(v[5]) + 10'(v[7]), 1'b0}
         + {2'd0, v[4], 2'b00};
    // floor of bsum / 9 by reciprocal, exact for sums up to 2295
    prod = 25'(bsum) * 25'd7282;
    unique case (ksel)
      K_EDGE:    s = 14'sd4 * e[4] - e[1] - e[3] - e[5] - e[7];
      K_SHARPEN: s = 14'sd5 * e[4] - e[1] - e[3] - e[5] - e[7];
      K_BOX:     s = $signed({5'd0, prod[24:16]});
      K_GAUSS:   s = $signed({6'd0, gsum[11:4]});
      K_EMBOSS:  s = -(14'sd2 * e[0]) - e[1] - e[3] + e[4] + e[5] + e[7] + 14'sd2 * e[8];
      default:   s = e[4];
    endcase
    if (s < 14'sd0) return 8'd0;
    else if (s > 14'sd255) return 8'd255;
    else return s[7:0];
  endfunction

  logic [3:0]        sent_q, remaining, bit_sel;
  logic [1:0]        kind;
  logic              issue, last_sel;
  logic [1:0]        cidx [3];
  logic [1:0]        ridx [3];
  win_t              sel_win;
  logic              x_valid_q, x_last_q, x_rdy, o_rdy;
  win_t              x_win_q;
  logic [10:0]       x_col_q;
  logic [11:0]       x_row_q;
  logic              o_valid_q, o_last_q;
  logic [3:0][7:0]   o_res_q, res_d;
  logic [10:0]       o_col_q;
  logic [11:0]       o_row_q;
  logic [2:0]        nch;
  logic [8:0][7:0]   lane;

  assign remaining = head_i.mask & ~sent_q;

  always_comb begin
    priority if (remaining[0]) kind = 2'd0;
    else if (remaining[1]) kind = 2'd1;
    else if (remaining[2]) kind = 2'd2;
    else kind = 2'd3;
  end

  assign bit_sel  = 4'b0001 << kind;
  assign last_sel = (remaining & ~bit_sel) == 4'd0;
  assign o_rdy    = !o_valid_q || out_if.ready;
  assign x_rdy    = !x_valid_q || o_rdy;
  assign issue    = !empty_i && x_rdy;
  assign pop_o    = issue && last_sel;

  // kind bit 0: last column taps, kind bit 1: bottom-row taps
  always_comb begin
    if (kind[0]) begin
      cidx[0] = head_i.col_zero ? 2'd2 : 2'd1;
      cidx[1] = 2'd2;
    end else begin
      cidx[0] = head_i.col_one ? 2'd1 : 2'd0;
      cidx[1] = 2'd1;
    end
    cidx[2] = 2'd2;
    if (kind[1]) begin
      ridx[0] = 2'd1;
      ridx[1] = 2'd2;
    end else begin
      ridx[0] = 2'd0;
      ridx[1] = 2'd1;
    end
    ridx[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sel_win[i*3+j] = head_i.win[4'(ridx[i]) * 4'd3 + 4'(cidx[j])];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q    <= '0;
      x_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (issue) sent_q <= last_sel ? 4'd0 : (sent_q | bit_sel);
      if (x_rdy) x_valid_q <= issue;
      if (o_rdy) o_valid_q <= x_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      x_win_q  <= sel_win;
      x_col_q  <= kind[0] ? head_i.col : head_i.col - 11'd1;
      x_row_q  <= kind[1] ? head_i.row : head_i.row - 12'd1;
      x_last_q <= last_sel;
    end
    if (o_rdy && x_valid_q) begin
      o_res_q  <= res_d;
      o_col_q  <= x_col_q;
      o_row_q  <= x_row_q;
      o_last_q <= x_last_q;
    end
  end

  always_comb begin
    if (cfg_i.chans == 3'd0) nch = 3'd1;
    else if (cfg_i.chans > 3'(MAX_CHANNELS)) nch = 3'(MAX_CHANNELS);
    else nch = cfg_i.chans;
    lane = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 9; k++) lane[k] = x_win_q[k][c*8 +: 8];
      res_d[c] = (3'(c) < nch) ? filt(lane, cfg_i.kernel) : 8'd0;
    end
  end

  assign out_if.valid    = o_valid_q;
  assign out_if.res_a    = o_res_q[0];
  assign out_if.res_b    = o_res_q[1];
  assign out_if.res_c    = o_res_q[2];
  assign out_if.res_d    = o_res_q[3];
  assign out_if.out_col  = o_col_q;
  assign out_if.out_row  = o_row_q;
  assign out_if.run_last = o_last_q;

endmodule

/* hw/rtl/image_convolution_3x3.sv */
// streaming 3x3 filter, one pixel word accepted per cycle while the queue has room
// a result word passes the read stage, the queue and the x and o registers to the output
// up to four results per pixel, one per cycle unless the output stalls; a 4-deep queue between
// line-buffer front and filter back absorbs the end-of-row pairs, the final row is throttled
// reset: counters, window and queue clear; line buffers hold garbage until written
// configuration resets to identity kernel, 2048 x 4096, three channels
module image_convolution_3x3 (
  input  logic clk_i,
  input  logic rst_ni,
  pix_if.sink  in_if,
  res_if.source out_if,
  cfg_if.sink  cfg
);
  import icv_pkg::*;

  cfg_t                 cfg_q;
  entry_t               entry, head;
  logic                 push, pop, empty;
  logic [QCW-1:0]       count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kernel <= K_IDENT;
      cfg_q.width  <= 12'd2048;
      cfg_q.height <= 13'd4096;
      cfg_q.chans  <= 3'd3;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_KERNEL:   cfg_q.kernel <= cfg.data[2:0];
        REG_WIDTH:    cfg_q.width  <= cfg.data[11:0];
        REG_HEIGHT:   cfg_q.height <= cfg.data[12:0];
        REG_CHANNELS: cfg_q.chans  <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  icv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_i        (cfg_q),
    .fifo_count_i (count),
    .push_o       (push),
    .entry_o      (entry)
  );

  icv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .count_o (count)
  );

  icv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_if  (out_if)
  );

endmodule

/* hw/rtl/icv_checker.sv */
module icv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [7:0]  out_res_a_i,
  input logic [10:0] out_col_i,
  input logic [11:0] out_row_i,
  input logic        out_last_i,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_res_a_i) && $stable(out_col_i)
      && $stable(out_row_i) && $stable(out_last_i))
    else $error("result word changed while stalled");

  // register writes never back-pressure
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config port not ready");

  // no result word while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind image_convolution_3x3 icv_checker u_icv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_res_a_i (out_if.res_a),
  .out_col_i   (out_if.out_col),
  .out_row_i   (out_if.out_row),
  .out_last_i  (out_if.run_last),
  .cfg_valid_i (cfg.valid),
  .cfg_ready_i (cfg.ready)
);
